// ===== rtl/gfpd_pkg.sv =====
package gfpd_pkg;

  // field widths of the item and result payloads
  localparam int REQ_W    = 1;
  localparam int INDEX_W  = 6;
  localparam int COEFF_W  = 8;
  localparam int KIND_W   = 2;
  localparam int DEG_W    = 5;

  // configuration registers
  localparam int DEGREE_REG_W = 6;
  localparam int FIELD_REG_W  = 9;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 3;
  localparam int REG_LSB      = 2;
  localparam int REG_IDX_W    = APB_ADDR_W - REG_LSB;

  localparam logic [REG_IDX_W-1:0] REG_DEGREE = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_FIELD  = 1'd1;

  localparam logic [DEGREE_REG_W-1:0] DEGREE_RST = 6'd1;
  localparam logic [FIELD_REG_W-1:0]  FIELD_RST  = 9'd285;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOAD = 1'd0;
  localparam logic [REQ_W-1:0] REQ_DIV  = 1'd1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_QUOT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REM  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [INDEX_W-1:0] coeff_index;
    logic [COEFF_W-1:0] coeff_value;
    logic               last_coeff;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]  result_kind;
    logic [DEG_W-1:0]   coeff_degree;
    logic [COEFF_W-1:0] out_value;
    logic               last_out;
  } out_item_t;

  // classified command between front and back
  typedef struct packed {
    logic               is_load;
    logic [INDEX_W-1:0] idx;
    logic [COEFF_W-1:0] value;
    logic               last;
  } cmd_t;

endpackage

// ===== rtl/gf_poly_divide.sv =====
// Polynomial divider over GF(2^SYM_BITS) by synthetic division. Load divisor
// coefficients first (req_type load, coeff_index = degree), set divisor_degree
// and field_poly over the APB port while the block is idle, then stream the
// dividend highest degree first with last_coeff on the constant term. The
// first divisor_degree coefficients of a division only fill the remainder;
// every later one yields one quotient coefficient, and the last one is
// followed by the divisor_degree remainder coefficients, highest first, the
// final result flagged by last_out. A zero leading divisor coefficient gives
// no quotient and a single error result instead of the remainder. A four deep
// command queue decouples the input from the execution unit, which stores a
// load directly, shifts a dividend coefficient into the remainder while it
// fills and, once it reduces, registers the quotient multiply before the lane
// update; on the first coefficient of each division it first runs the
// iterative inverse of the leading coefficient, and after the last coefficient
// it drains the remainder (or gives the error result); a full result queue
// stalls the execution unit.
module gf_poly_divide #(
  parameter int MAX_DEGREE = 32,
  parameter int SYM_BITS   = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // item input
  input  logic                                push,
  output logic                                full,
  input  gfpd_pkg::in_item_t                  in_data,
  // result output
  output logic                                empty,
  input  logic                                pop,
  output gfpd_pkg::out_item_t                 out_data,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gfpd_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [gfpd_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [gfpd_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  logic [gfpd_pkg::DEGREE_REG_W-1:0] degree_r, degree_nxt;
  logic [gfpd_pkg::FIELD_REG_W-1:0]  field_r, field_nxt;
  logic [gfpd_pkg::REG_IDX_W-1:0]    reg_idx;
  logic                              reg_wr;

  logic                 cmd_pop;
  logic                 cmd_empty;
  gfpd_pkg::cmd_t       cmd_data;
  logic                 res_push;
  logic                 res_full;
  gfpd_pkg::out_item_t  res_data;

  // register file, one transfer per access phase, no wait states
  assign pready  = 1'b1;
  assign reg_idx = paddr[gfpd_pkg::APB_ADDR_W-1:gfpd_pkg::REG_LSB];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    degree_nxt = degree_r;
    field_nxt  = field_r;
    prdata     = '0;
    case (reg_idx)
      gfpd_pkg::REG_DEGREE: begin
        prdata = gfpd_pkg::APB_DATA_W'(degree_r);
        if (reg_wr) begin
          degree_nxt = pwdata[gfpd_pkg::DEGREE_REG_W-1:0];
        end
      end
      gfpd_pkg::REG_FIELD: begin
        prdata = gfpd_pkg::APB_DATA_W'(field_r);
        if (reg_wr) begin
          field_nxt = pwdata[gfpd_pkg::FIELD_REG_W-1:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= gfpd_pkg::DEGREE_RST;
      field_r  <= gfpd_pkg::FIELD_RST;
    end else begin
      degree_r <= degree_nxt;
      field_r  <= field_nxt;
    end
  end

  // front: takes items, drops out of range loads, queues the rest
  gfpd_front #(
    .MAX_DEGREE (MAX_DEGREE),
    .CMD_DEPTH  (CMD_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cmd_pop   (cmd_pop),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_data)
  );

  // back: divisor store, inverse, remainder lanes, result sequencing
  gfpd_back #(
    .MAX_DEGREE (MAX_DEGREE),
    .SYM_BITS   (SYM_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_degree (degree_r),
    .cfg_field  (field_r),
    .cmd_empty  (cmd_empty),
    .cmd_data   (cmd_data),
    .cmd_pop    (cmd_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_data   (res_data)
  );

  // result queue, keeps the back running while the consumer stalls
  gfpd_fifo #(
    .WIDTH ($bits(gfpd_pkg::out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res_data),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (out_data),
    .empty   (empty)
  );

endmodule

// ===== rtl/gfpd_fifo.sv =====
module gfpd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    end
    if (do_rd) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

// ===== rtl/gfpd_front.sv =====
module gfpd_front #(
  parameter int MAX_DEGREE = 32,
  parameter int CMD_DEPTH  = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  gfpd_pkg::in_item_t  in_data,
  input  logic                cmd_pop,
  output logic                cmd_empty,
  output gfpd_pkg::cmd_t      cmd_data
);

  gfpd_pkg::cmd_t cmd_in;
  logic           is_load;
  logic           keep;
  logic           cmd_wr;

  // out of range loads are taken and dropped here
  always_comb begin
    is_load        = (in_data.req_type == gfpd_pkg::REQ_LOAD);
    keep           = !is_load || (int'(in_data.coeff_index) <= MAX_DEGREE);
    cmd_in.is_load = is_load;
    cmd_in.idx     = in_data.coeff_index;
    cmd_in.value   = in_data.coeff_value;
    cmd_in.last    = !is_load && in_data.last_coeff;
  end

  assign cmd_wr = push && !full && keep;

  gfpd_fifo #(
    .WIDTH ($bits(gfpd_pkg::cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_wr),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd_data),
    .empty   (cmd_empty)
  );

endmodule

// ===== rtl/gfpd_back.sv =====
module gfpd_back #(
  parameter int MAX_DEGREE = 32,
  parameter int SYM_BITS   = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [gfpd_pkg::DEGREE_REG_W-1:0]    cfg_degree,
  input  logic [gfpd_pkg::FIELD_REG_W-1:0]     cfg_field,
  input  logic                                 cmd_empty,
  input  gfpd_pkg::cmd_t                       cmd_data,
  output logic                                 cmd_pop,
  input  logic                                 res_full,
  output logic                                 res_push,
  output gfpd_pkg::out_item_t                  res_data
);

  localparam int SW       = SYM_BITS;
  localparam int DW       = $clog2(MAX_DEGREE + 1);
  localparam int RW       = $clog2(MAX_DEGREE);
  localparam int ITW      = $clog2(SYM_BITS);
  localparam int WIDE_W   = 16;
  localparam int DEG_WIDE = 8;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INV   = 3'd1;
  localparam logic [2:0] S_STEP  = 3'd2;
  localparam logic [2:0] S_UPD   = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;

  function automatic logic [SW-1:0] gf_mul(input logic [SW-1:0] a,
                                           input logic [SW-1:0] b,
                                           input logic [SW-1:0] red);
    logic [SW-1:0] acc;
    logic [SW-1:0] aa;
    logic [SW-1:0] bb;
    logic          top;
    acc = '0;
    aa  = a;
    bb  = b;
    for (int i = 0; i < SW; i++) begin
      if (bb[0]) begin
        acc = acc ^ aa;
      end
      bb  = bb >> 1;
      top = aa[SW-1];
      aa  = aa << 1;
      if (top) begin
        aa = aa ^ red;
      end
    end
    return acc;
  endfunction

  function automatic logic [gfpd_pkg::COEFF_W-1:0] to_out(input logic [SW-1:0] v);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(v);
    return w[gfpd_pkg::COEFF_W-1:0];
  endfunction

  logic [2:0]     state_r, state_nxt;
  gfpd_pkg::cmd_t cur_r, cur_nxt;
  logic [DW-1:0]  cnt_r, cnt_nxt;
  logic [SW-1:0]  inv_r, inv_nxt;
  logic [SW-1:0]  pw_r, pw_nxt;
  logic [SW-1:0]  base_r, base_nxt;
  logic [ITW-1:0] it_r, it_nxt;
  logic [SW-1:0]  q_r, q_nxt;
  logic [DW-1:0]  j_r, j_nxt;
  logic [SW-1:0]  rem_r [MAX_DEGREE];
  logic [SW-1:0]  rem_nxt [MAX_DEGREE];

  logic [SW-1:0]  div_lo_r [MAX_DEGREE];
  logic [SW-1:0]  div_top_r;

  logic [DW-1:0]        d;
  logic [DW-1:0]        dm1;
  logic [DW-1:0]        jm1;
  logic [DEG_WIDE-1:0]  jm1_w;
  logic [SW-1:0]        lead;
  logic [SW-1:0]        red;
  logic [SW-1:0]        c_in;
  logic [SW-1:0]        ld_val;
  logic [WIDE_W-1:0]    red_w;
  logic [WIDE_W-1:0]    cin_w;
  logic [WIDE_W-1:0]    ld_w;
  logic [SW-1:0]        rem_top;
  logic [SW-1:0]        pw_mul;
  logic [SW-1:0]        base_sq;
  logic [SW-1:0]        pw_step;
  logic [SW-1:0]        prod [MAX_DEGREE];
  logic                 load_we;

  // operand preparation
  always_comb begin
    if (cfg_degree == '0) begin
      d = DW'(1);
    end else if (int'(cfg_degree) > MAX_DEGREE) begin
      d = DW'(MAX_DEGREE);
    end else begin
      d = DW'(cfg_degree);
    end
    dm1    = d - DW'(1);
    jm1    = j_r - DW'(1);
    jm1_w  = DEG_WIDE'(jm1);
    red_w  = WIDE_W'(cfg_field);
    red    = red_w[SW-1:0];
    cin_w  = WIDE_W'(cur_r.value);
    c_in   = cin_w[SW-1:0];
    ld_w   = WIDE_W'(cmd_data.value);
    ld_val = ld_w[SW-1:0];
    if (d == DW'(MAX_DEGREE)) begin
      lead = div_top_r;
    end else begin
      lead = div_lo_r[d[RW-1:0]];
    end
    rem_top = rem_r[dm1[RW-1:0]];
    pw_mul  = gf_mul(pw_r, base_r, red);
    base_sq = gf_mul(base_r, base_r, red);
    // exponent 2^m-2 has every bit set but bit 0
    pw_step = (it_r != '0) ? pw_mul : pw_r;
    for (int j = 0; j < MAX_DEGREE; j++) begin
      prod[j] = gf_mul(q_r, div_lo_r[j], red);
    end
  end

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    cnt_nxt   = cnt_r;
    inv_nxt   = inv_r;
    pw_nxt    = pw_r;
    base_nxt  = base_r;
    it_nxt    = it_r;
    q_nxt     = q_r;
    j_nxt     = j_r;
    rem_nxt   = rem_r;
    cmd_pop   = 1'b0;
    load_we   = 1'b0;
    res_push  = 1'b0;
    res_data  = '0;

    case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          if (cmd_data.is_load) begin
            load_we = 1'b1;
          end else begin
            cur_nxt = cmd_data;
            if (cnt_r == '0) begin
              state_nxt = S_INV;
              pw_nxt    = SW'(1);
              base_nxt  = lead;
              it_nxt    = '0;
            end else begin
              state_nxt = S_STEP;
            end
          end
        end
      end

      S_INV: begin
        pw_nxt   = pw_step;
        base_nxt = base_sq;
        it_nxt   = it_r + ITW'(1);
        if (it_r == ITW'(SYM_BITS - 1)) begin
          inv_nxt   = pw_step;
          state_nxt = S_STEP;
        end
      end

      S_STEP: begin
        if (cnt_r < d) begin
          // shift-in phase
          for (int j = 1; j < MAX_DEGREE; j++) begin
            if (j < int'(d)) begin
              rem_nxt[j] = rem_r[j-1];
            end
          end
          rem_nxt[0] = c_in;
          cnt_nxt    = cnt_r + DW'(1);
          if (cur_r.last) begin
            state_nxt = S_DRAIN;
            j_nxt     = d;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          q_nxt     = gf_mul(rem_top, inv_r, red);
          state_nxt = S_UPD;
        end
      end

      S_UPD: begin
        if (inv_r == '0 || !res_full) begin
          for (int j = 1; j < MAX_DEGREE; j++) begin
            if (j < int'(d)) begin
              rem_nxt[j] = rem_r[j-1] ^ prod[j];
            end
          end
          rem_nxt[0] = c_in ^ prod[0];
          if (inv_r != '0) begin
            res_push             = 1'b1;
            res_data.result_kind = gfpd_pkg::KIND_QUOT;
            res_data.out_value   = to_out(q_r);
          end
          if (cur_r.last) begin
            state_nxt = S_DRAIN;
            j_nxt     = d;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_DRAIN: begin
        if (!res_full) begin
          res_push = 1'b1;
          if (inv_r == '0) begin
            res_data.result_kind = gfpd_pkg::KIND_ERR;
            res_data.last_out    = 1'b1;
            rem_nxt              = '{default: '0};
            cnt_nxt              = '0;
            state_nxt            = S_IDLE;
          end else begin
            res_data.result_kind  = gfpd_pkg::KIND_REM;
            res_data.coeff_degree = jm1_w[gfpd_pkg::DEG_W-1:0];
            res_data.out_value    = to_out(rem_top);
            res_data.last_out     = (j_r == DW'(1));
            // move the next lower coefficient up to the top tap
            for (int j = 1; j < MAX_DEGREE; j++) begin
              if (j < int'(d)) begin
                rem_nxt[j] = rem_r[j-1];
              end
            end
            rem_nxt[0] = '0;
            j_nxt      = jm1;
            if (j_r == DW'(1)) begin
              rem_nxt   = '{default: '0};
              cnt_nxt   = '0;
              state_nxt = S_IDLE;
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      inv_r   <= '0;
      rem_r   <= '{default: '0};
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      inv_r   <= inv_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    pw_r   <= pw_nxt;
    base_r <= base_nxt;
    it_r   <= it_nxt;
    q_r    <= q_nxt;
    j_r    <= j_nxt;
    if (load_we) begin
      if (int'(cmd_data.idx) == MAX_DEGREE) begin
        div_top_r <= ld_val;
      end else begin
        div_lo_r[cmd_data.idx[RW-1:0]] <= ld_val;
      end
    end
  end

endmodule
